>>> rtl/svb_pkg.sv
// Shared types, constants and helpers for the shadow volume builder.
package svb_pkg;

    localparam int MAX_TRIANGLES = 4096;
    localparam int SLOT_W        = $clog2(MAX_TRIANGLES);
    localparam int VTX_W         = 16;
    localparam int IDX_W         = 17;
    localparam int POS_W         = 32;
    localparam int NRM_W         = 16;
    localparam int KIND_W        = 3;
    localparam int CNT_W         = 15;
    localparam int Q_DEPTH       = 2;
    localparam int QP_W          = $clog2(Q_DEPTH);
    localparam int QC_W          = $clog2(Q_DEPTH + 1);
    localparam int ADDR_W        = 5;

    localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;
    localparam logic signed [63:0] FACE_LIMIT  = -64'sd10;
    localparam logic [30:0]        RANGE_RESET = 31'd65536;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_EXTRUDE = 2'd1,
        ACT_EDGE1   = 2'd2,
        ACT_EDGE2   = 2'd3
    } t_action;

    localparam logic [KIND_W-1:0] KIND_ACK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TWIN  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BACK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SIDE  = 3'd4;

    localparam logic [2:0] REG_LIGHT_X     = 3'd0;
    localparam logic [2:0] REG_LIGHT_Y     = 3'd1;
    localparam logic [2:0] REG_LIGHT_Z     = 3'd2;
    localparam logic [2:0] REG_DIRECTIONAL = 3'd3;
    localparam logic [2:0] REG_RANGE       = 3'd4;
    localparam logic [2:0] REG_TWIN_OFFSET = 3'd5;

    typedef struct packed {
        logic [VTX_W-1:0] v0;
        logic [VTX_W-1:0] v1;
        logic [VTX_W-1:0] v2;
        logic             front;
        logic             marked;
    } t_tri;

    localparam int TRI_W = $bits(t_tri);

    typedef struct packed {
        t_action                  action;
        logic [SLOT_W-1:0]        slot_a;
        logic [SLOT_W-1:0]        slot_b;
        logic [VTX_W-1:0]         vtx_a;
        logic [VTX_W-1:0]         vtx_b;
        logic [VTX_W-1:0]         vtx_c;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NRM_W-1:0]  nrm_x;
        logic signed [NRM_W-1:0]  nrm_y;
        logic signed [NRM_W-1:0]  nrm_z;
    } t_item;

    typedef struct packed {
        logic signed [POS_W-1:0] light_x;
        logic signed [POS_W-1:0] light_y;
        logic signed [POS_W-1:0] light_z;
        logic                    directional;
        logic [30:0]             shadow_range;
        logic [IDX_W-1:0]        twin_offset;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        a;
        logic [IDX_W-1:0]        b;
        logic [IDX_W-1:0]        c;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic signed [POS_W-1:0] tz;
        logic                    facing;
        logic                    last;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Twin index: source index plus the configured twin offset, wrapped to the index width.
    function automatic logic [IDX_W-1:0] twin_idx(input logic [VTX_W-1:0] v,
                                                  input logic [IDX_W-1:0] off);
        return {1'b0, v} + off;
    endfunction

endpackage

>>> rtl/svb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/svb_sqdiv.sv
// Shared iterative unit: 64-bit integer square root and 63/32-bit division.
module svb_sqdiv import svb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start_root,
    input  logic        i_start_div,
    input  logic [63:0] i_x,
    input  logic [62:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_root,
    output logic [32:0] o_quot
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_ROOT = 3'b010,
        U_DIV  = 3'b100
    } t_ustate;

    t_ustate     r_state;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_done;

    logic [63:0] trial;
    logic        take;
    logic [32:0] part;
    logic        ge;
    logic [32:0] part_sub;

    assign trial    = r_res + r_bit;
    assign take     = r_x >= trial;
    assign part     = {r_rem, r_x[62]};
    assign ge       = part >= {1'b0, r_den};
    assign part_sub = part - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                U_IDLE: begin
                    if (i_start_root) begin
                        r_x     <= i_x;
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_cnt   <= 6'd31;
                        r_state <= U_ROOT;
                    end else if (i_start_div) begin
                        r_x     <= {1'b0, i_num};
                        r_res   <= '0;
                        r_rem   <= '0;
                        r_den   <= i_den;
                        r_cnt   <= 6'd62;
                        r_state <= U_DIV;
                    end
                end
                U_ROOT: begin
                    if (take) begin
                        r_x   <= r_x - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                U_DIV: begin
                    r_rem <= ge ? part_sub[31:0] : part[31:0];
                    r_res <= {r_res[62:0], ge};
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
    assign o_quot = r_res[32:0];

endmodule

>>> rtl/svb_front.sv
// Front end: input transaction acceptance and a short queue to the back end.
module svb_front import svb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_avail,
    output t_item o_item,
    input  logic  i_pop
);

    t_item            r_q [Q_DEPTH];
    logic [QP_W-1:0]  r_wp;
    logic [QP_W-1:0]  r_rp;
    logic [QC_W-1:0]  r_cnt;
    logic             push;

    assign o_ready = r_cnt != QC_W'(Q_DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/svb_exec.sv
// Back end: facing test, twin extrusion, cap and side emission, output register.
module svb_exec import svb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_avail,
    input  t_item   i_item,
    output logic    o_pop,
    output t_result o_res,
    output logic    o_res_valid,
    input  logic    i_res_ready
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_DISP  = 15'h0002,
        S_MUL   = 15'h0004,
        S_LDWR  = 15'h0008,
        S_CHK   = 15'h0010,
        S_SQRT  = 15'h0020,
        S_MULQ  = 15'h0040,
        S_DIVS  = 15'h0080,
        S_DIVW  = 15'h0100,
        S_EMITX = 15'h0200,
        S_RD0   = 15'h0400,
        S_RD1   = 15'h0800,
        S_EMITE = 15'h1000,
        S_WR0   = 15'h2000,
        S_WR1   = 15'h4000
    } t_state;

    t_state                  r_state, n_state;
    t_item                   r_item;
    logic [1:0]              r_step;
    logic [63:0]             r_acc;
    logic [63:0]             r_r2;
    logic [31:0]             r_len;
    logic [62:0]             r_num;
    logic signed [POS_W-1:0] r_tx, r_ty, r_tz;
    t_tri                    r_t0, r_t1;
    t_result                 r_out;
    logic                    r_ov;

    logic signed [32:0]      dx, dy, dz, d_k;
    logic signed [POS_W-1:0] l_k, p_k;
    logic signed [NRM_W-1:0] n_k;
    logic [32:0]             mag33;
    logic                    all_small;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      prod;
    logic                    can_emit;
    logic                    load_out;
    t_result                 out_new;
    logic                    facing;
    logic signed [34:0]      comp_sum;
    logic signed [31:0]      comp_sat;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    t_tri                    ram_wdata;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [TRI_W-1:0]        ram_rdata;

    logic                    sq_start, dv_start, sq_done;
    logic [31:0]             sq_root;
    logic [32:0]             sq_quot;

    logic                    t1_marked;
    logic [3:0]              en;
    logic                    e_last;
    t_tri                    drv;
    logic [VTX_W-1:0]        side_a, side_b;
    t_result                 e_res;
    t_tri                    cap_t;

    function automatic logic signed [32:0] diff33(input logic signed [31:0] p,
                                                  input logic signed [31:0] l);
        return {p[31], p} - {l[31], l};
    endfunction

    // Strictly inside (-2^31, 2^31).
    function automatic logic in_range(input logic signed [32:0] d);
        return (d[32:31] == 2'b00) || (d[32:31] == 2'b11 && d[30:0] != '0);
    endfunction

    function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
        return {{3{v[31]}}, v};
    endfunction

    svb_ram #(.WIDTH(TRI_W), .DEPTH(MAX_TRIANGLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    svb_sqdiv u_sqdiv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_root (sq_start),
        .i_start_div  (dv_start),
        .i_x          (r_acc),
        .i_num        (r_num),
        .i_den        (r_len),
        .o_done       (sq_done),
        .o_root       (sq_root),
        .o_quot       (sq_quot)
    );

    assign dx = diff33(r_item.pos_x, i_cfg.light_x);
    assign dy = diff33(r_item.pos_y, i_cfg.light_y);
    assign dz = diff33(r_item.pos_z, i_cfg.light_z);
    assign all_small = in_range(dx) && in_range(dy) && in_range(dz);

    always_comb begin
        case (r_step)
            2'd0: begin
                d_k = dx; l_k = i_cfg.light_x; p_k = r_item.pos_x; n_k = r_item.nrm_x;
            end
            2'd1: begin
                d_k = dy; l_k = i_cfg.light_y; p_k = r_item.pos_y; n_k = r_item.nrm_y;
            end
            default: begin
                d_k = dz; l_k = i_cfg.light_z; p_k = r_item.pos_z; n_k = r_item.nrm_z;
            end
        endcase
    end

    assign mag33 = d_k[32] ? 33'(-d_k) : 33'(d_k);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            if (r_item.action == ACT_LOAD) begin
                mul_a = i_cfg.directional ? {l_k[31], l_k} : d_k;
                mul_b = {{17{n_k[15]}}, n_k};
            end else if (r_step == 2'd3) begin
                mul_a = {2'b00, i_cfg.shadow_range};
                mul_b = {2'b00, i_cfg.shadow_range};
            end else begin
                mul_a = d_k;
                mul_b = d_k;
            end
        end else if (r_state == S_MULQ) begin
            mul_a = {2'b00, mag33[30:0]};
            mul_b = {2'b00, i_cfg.shadow_range};
        end
    end

    assign prod     = mul_a * mul_b;
    assign facing   = $signed(r_acc) < FACE_LIMIT;
    assign can_emit = !r_ov || i_res_ready;

    // Twin component: light plus signed, rounded extrusion.
    assign comp_sum = d_k[32] ? sx35(l_k) - {2'b00, sq_quot}
                              : sx35(l_k) + {2'b00, sq_quot};
    assign comp_sat = sat32(comp_sum);

    // Edge emission: four slots, caps then sides, disabled slots skipped.
    assign t1_marked = r_t1.marked || (r_item.slot_a == r_item.slot_b);

    always_comb begin
        if (r_item.action == ACT_EDGE1) begin
            en  = {r_t0.front, r_t0.front,
                   r_t0.front && !r_t0.marked, r_t0.front && !r_t0.marked};
            drv = r_t0;
        end else begin
            en  = {r_t0.front ^ r_t1.front, r_t0.front ^ r_t1.front,
                   !t1_marked, !r_t0.marked};
            drv = r_t0.front ? r_t0 : r_t1;
        end
    end

    always_comb begin
        if (drv.v0 != r_item.vtx_a && drv.v0 != r_item.vtx_b) begin
            side_a = drv.v2; side_b = drv.v1;
        end else if (drv.v1 != r_item.vtx_a && drv.v1 != r_item.vtx_b) begin
            side_a = drv.v0; side_b = drv.v2;
        end else if (drv.v2 != r_item.vtx_a && drv.v2 != r_item.vtx_b) begin
            side_a = drv.v1; side_b = drv.v0;
        end else begin
            side_a = '0; side_b = '0;
        end
    end

    assign e_last = ((en >> r_step) & 4'b1110) == 4'b0000;
    assign cap_t  = (r_step == 2'd0) ? r_t0 : r_t1;

    always_comb begin
        e_res      = '0;
        e_res.last = e_last;
        case (r_step)
            2'd0, 2'd1: begin
                if (r_item.action == ACT_EDGE1) begin
                    if (r_step == 2'd0) begin
                        e_res.kind = KIND_FRONT;
                        e_res.a = {1'b0, r_t0.v0};
                        e_res.b = {1'b0, r_t0.v1};
                        e_res.c = {1'b0, r_t0.v2};
                    end else begin
                        e_res.kind = KIND_BACK;
                        e_res.a = twin_idx(r_t0.v2, i_cfg.twin_offset);
                        e_res.b = twin_idx(r_t0.v1, i_cfg.twin_offset);
                        e_res.c = twin_idx(r_t0.v0, i_cfg.twin_offset);
                    end
                end else if (cap_t.front) begin
                    e_res.kind = KIND_FRONT;
                    e_res.a = {1'b0, cap_t.v0};
                    e_res.b = {1'b0, cap_t.v1};
                    e_res.c = {1'b0, cap_t.v2};
                end else begin
                    e_res.kind = KIND_BACK;
                    e_res.a = twin_idx(cap_t.v0, i_cfg.twin_offset);
                    e_res.b = twin_idx(cap_t.v1, i_cfg.twin_offset);
                    e_res.c = twin_idx(cap_t.v2, i_cfg.twin_offset);
                end
            end
            2'd2: begin
                e_res.kind = KIND_SIDE;
                e_res.a = {1'b0, side_a};
                e_res.b = {1'b0, side_b};
                e_res.c = twin_idx(side_a, i_cfg.twin_offset);
            end
            default: begin
                e_res.kind = KIND_SIDE;
                e_res.a = {1'b0, side_b};
                e_res.b = twin_idx(side_b, i_cfg.twin_offset);
                e_res.c = twin_idx(side_a, i_cfg.twin_offset);
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_item.slot_a;
        ram_wdata = '0;
        ram_raddr = r_item.slot_a;
        load_out  = 1'b0;
        out_new   = '0;
        sq_start  = 1'b0;
        dv_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop   = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_item.action)
                    ACT_LOAD:    n_state = S_MUL;
                    ACT_EXTRUDE: begin
                        n_state = (i_cfg.directional || !all_small) ? S_EMITX : S_MUL;
                    end
                    default:     n_state = S_RD0;
                endcase
            end
            S_MUL: begin
                if (r_item.action == ACT_LOAD && r_step == 2'd2) begin
                    n_state = S_LDWR;
                end else if (r_step == 2'd3) begin
                    n_state = S_CHK;
                end
            end
            S_LDWR: begin
                if (can_emit) begin
                    ram_we         = 1'b1;
                    ram_wdata      = '{v0: r_item.vtx_a, v1: r_item.vtx_b,
                                       v2: r_item.vtx_c, front: facing, marked: 1'b0};
                    load_out       = 1'b1;
                    out_new.kind   = KIND_ACK;
                    out_new.facing = facing;
                    out_new.last   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CHK: begin
                if (r_acc != '0 && r_acc < r_r2) begin
                    sq_start = 1'b1;
                    n_state  = S_SQRT;
                end else begin
                    n_state = S_EMITX;
                end
            end
            S_SQRT: begin
                if (sq_done) begin
                    n_state = S_MULQ;
                end
            end
            S_MULQ: n_state = S_DIVS;
            S_DIVS: begin
                dv_start = 1'b1;
                n_state  = S_DIVW;
            end
            S_DIVW: begin
                if (sq_done) begin
                    n_state = (r_step == 2'd2) ? S_EMITX : S_MULQ;
                end
            end
            S_EMITX: begin
                if (can_emit) begin
                    load_out     = 1'b1;
                    out_new.kind = KIND_TWIN;
                    out_new.tx   = r_tx;
                    out_new.ty   = r_ty;
                    out_new.tz   = r_tz;
                    out_new.last = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD0: begin
                ram_raddr = r_item.slot_b;
                n_state   = (r_item.action == ACT_EDGE1) ? S_EMITE : S_RD1;
            end
            S_RD1: n_state = S_EMITE;
            S_EMITE: begin
                if (!en[r_step] || can_emit) begin
                    load_out = en[r_step];
                    out_new  = e_res;
                    if (r_step == 2'd3) begin
                        n_state = S_WR0;
                    end
                end
            end
            S_WR0: begin
                ram_we    = (r_item.action == ACT_EDGE2) || r_t0.front;
                ram_wdata = '{v0: r_t0.v0, v1: r_t0.v1, v2: r_t0.v2,
                              front: r_t0.front, marked: 1'b1};
                n_state   = (r_item.action == ACT_EDGE2) ? S_WR1 : S_IDLE;
            end
            S_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = r_item.slot_b;
                ram_wdata = '{v0: r_t1.v0, v1: r_t1.v1, v2: r_t1.v2,
                              front: r_t1.front, marked: 1'b1};
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: r_step <= '0;
                S_MUL: r_step <= r_step + 2'd1;
                S_SQRT: r_step <= '0;
                S_DIVW: begin
                    if (sq_done) begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_RD0: r_step <= '0;
                S_EMITE: begin
                    if (!en[r_step] || can_emit) begin
                        r_step <= r_step + 2'd1;
                    end
                end
                default: r_step <= r_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    r_item <= i_item;
                end
            end
            S_DISP: begin
                // Default twin: the position itself, or position plus light.
                if (i_cfg.directional) begin
                    r_tx <= sat32(sx35(r_item.pos_x) + sx35(i_cfg.light_x));
                    r_ty <= sat32(sx35(r_item.pos_y) + sx35(i_cfg.light_y));
                    r_tz <= sat32(sx35(r_item.pos_z) + sx35(i_cfg.light_z));
                end else begin
                    r_tx <= r_item.pos_x;
                    r_ty <= r_item.pos_y;
                    r_tz <= r_item.pos_z;
                end
            end
            S_MUL: begin
                if (r_step == 2'd3) begin
                    r_r2 <= prod[63:0];
                end else begin
                    r_acc <= ((r_step == 2'd0) ? 64'd0 : r_acc) + prod[63:0];
                end
            end
            S_SQRT: begin
                if (sq_done) begin
                    r_len <= sq_root;
                end
            end
            S_MULQ: r_num <= prod[62:0] + {32'd0, r_len[31:1]};
            S_DIVW: begin
                if (sq_done) begin
                    case (r_step)
                        2'd0:    r_tx <= comp_sat;
                        2'd1:    r_ty <= comp_sat;
                        default: r_tz <= comp_sat;
                    endcase
                end
            end
            S_RD0: r_t0 <= t_tri'(ram_rdata);
            S_RD1: r_t1 <= t_tri'(ram_rdata);
            default: r_acc <= r_acc;
        endcase
    end

    // Output register: a waiting result holds the next emission until i_res_ready takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= out_new;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_ov;

endmodule

>>> rtl/shadow_volume_builder_core.sv
// Top level: APB register file, front queue and back end of the shadow volume builder.
// A load or a directional or far-away twin needs no root; a point-light twin inside
//   range runs a 32-step root plus three 63-step divides on the shared unit.
// One item is worked on at a time in the back end, which takes no new item until
//   the last is through; waiting items sit in the front queue.
// Reset is synchronous, active low: control, queue and registers clear; the
//   triangle store is not cleared and a slot reads as undefined until loaded.
module shadow_volume_builder_core import svb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_action,
    input  logic [SLOT_W-1:0]       i_slot_a,
    input  logic [SLOT_W-1:0]       i_slot_b,
    input  logic [VTX_W-1:0]        i_vtx_a,
    input  logic [VTX_W-1:0]        i_vtx_b,
    input  logic [VTX_W-1:0]        i_vtx_c,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [NRM_W-1:0] i_nrm_x,
    input  logic signed [NRM_W-1:0] i_nrm_y,
    input  logic signed [NRM_W-1:0] i_nrm_z,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [KIND_W-1:0]       o_kind,
    output logic [IDX_W-1:0]        o_out_a,
    output logic [IDX_W-1:0]        o_out_b,
    output logic [IDX_W-1:0]        o_out_c,
    output logic signed [POS_W-1:0] o_twin_x,
    output logic signed [POS_W-1:0] o_twin_y,
    output logic signed [POS_W-1:0] o_twin_z,
    output logic                    o_facing,
    output logic                    o_last,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg             r_cfg;
    logic [CNT_W-1:0] r_emit_cnt;
    logic [2:0]       reg_idx;
    logic             cfg_wr;
    t_item            in_item;
    t_item            q_item;
    logic             q_avail;
    logic             q_pop;
    t_result          res;
    logic             res_valid;
    logic             tri_taken;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_x      <= '0;
            r_cfg.light_y      <= '0;
            r_cfg.light_z      <= '0;
            r_cfg.directional  <= 1'b0;
            r_cfg.shadow_range <= RANGE_RESET;
            r_cfg.twin_offset  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LIGHT_X:     r_cfg.light_x      <= pwdata;
                REG_LIGHT_Y:     r_cfg.light_y      <= pwdata;
                REG_LIGHT_Z:     r_cfg.light_z      <= pwdata;
                REG_DIRECTIONAL: r_cfg.directional  <= pwdata[0];
                REG_RANGE:       r_cfg.shadow_range <= pwdata[30:0];
                REG_TWIN_OFFSET: r_cfg.twin_offset  <= pwdata[IDX_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LIGHT_X:     prdata = r_cfg.light_x;
            REG_LIGHT_Y:     prdata = r_cfg.light_y;
            REG_LIGHT_Z:     prdata = r_cfg.light_z;
            REG_DIRECTIONAL: prdata = {31'd0, r_cfg.directional};
            REG_RANGE:       prdata = {1'b0, r_cfg.shadow_range};
            REG_TWIN_OFFSET: prdata = {15'd0, r_cfg.twin_offset};
            default:         prdata = '0;
        endcase
    end

    assign in_item = '{action: t_action'(i_action), slot_a: i_slot_a, slot_b: i_slot_b,
                       vtx_a: i_vtx_a, vtx_b: i_vtx_b, vtx_c: i_vtx_c,
                       pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                       nrm_x: i_nrm_x, nrm_y: i_nrm_y, nrm_z: i_nrm_z};

    svb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_avail (q_avail),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    svb_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_avail     (q_avail),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (i_out_ready)
    );

    assign o_out_valid = res_valid;
    assign o_kind      = res.kind;
    assign o_out_a     = res.a;
    assign o_out_b     = res.b;
    assign o_out_c     = res.c;
    assign o_twin_x    = res.tx;
    assign o_twin_y    = res.ty;
    assign o_twin_z    = res.tz;
    assign o_facing    = res.facing;
    assign o_last      = res.last;

    // Count emitted triangles, saturating.
    assign tri_taken = o_out_valid && i_out_ready &&
                       (o_kind == KIND_FRONT || o_kind == KIND_BACK || o_kind == KIND_SIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_cnt <= '0;
        end else if (tri_taken && r_emit_cnt != COUNT_MAX) begin
            r_emit_cnt <= r_emit_cnt + 1'b1;
        end
    end

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_ACK || o_kind == KIND_TWIN)) |-> o_last)
        else $error("load ack or twin without last");

    a_tri_no_twin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_TWIN) |->
        (o_twin_x == '0 && o_twin_y == '0 && o_twin_z == '0))
        else $error("triangle result carries twin position");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_cnt == COUNT_MAX) |=> (r_emit_cnt == COUNT_MAX))
        else $error("emitted count left saturation");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("not idle after reset");

endmodule

>>> test/svb_checker.sv
// Checker for the shadow volume builder: predicts results from observed transactions.
module svb_checker import svb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_action,
    input  logic [SLOT_W-1:0]       i_slot_a,
    input  logic [SLOT_W-1:0]       i_slot_b,
    input  logic [VTX_W-1:0]        i_vtx_a,
    input  logic [VTX_W-1:0]        i_vtx_b,
    input  logic [VTX_W-1:0]        i_vtx_c,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [NRM_W-1:0] i_nrm_x,
    input  logic signed [NRM_W-1:0] i_nrm_y,
    input  logic signed [NRM_W-1:0] i_nrm_z,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic [IDX_W-1:0]        i_out_a,
    input  logic [IDX_W-1:0]        i_out_b,
    input  logic [IDX_W-1:0]        i_out_c,
    input  logic signed [POS_W-1:0] i_twin_x,
    input  logic signed [POS_W-1:0] i_twin_y,
    input  logic signed [POS_W-1:0] i_twin_z,
    input  logic                    i_facing,
    input  logic                    i_last,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    output int                      o_fail_count,
    output int                      o_pending
);

    t_tri                    tri_mem [MAX_TRIANGLES];
    t_result                 volume_q[$];
    logic signed [POS_W-1:0] lgt_x, lgt_y, lgt_z;
    logic                    is_dir;
    logic [30:0]             range_r;
    logic [IDX_W-1:0]        offset_r;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned res  = 0;
        longint unsigned bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint push_out(longint l, longint d, longint unsigned len);
        longint unsigned mag = (d < 0) ? -d : d;
        longint unsigned q   = (mag * range_r + len / 2) / len;
        longint          s   = (d < 0) ? -longint'(q) : longint'(q);
        return clamp32(l + s);
    endfunction

    task automatic emit(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                        logic [IDX_W-1:0] c, longint tx, longint ty, longint tz, logic f);
        t_result r;
        r.kind = kind; r.a = a; r.b = b; r.c = c;
        r.tx = tx[31:0]; r.ty = ty[31:0]; r.tz = tz[31:0];
        r.facing = f; r.last = 1'b0;
        volume_q.push_back(r);
    endtask

    task automatic emit_sides(t_tri t, logic [VTX_W-1:0] e0, logic [VTX_W-1:0] e1);
        logic [VTX_W-1:0] a, b;
        if (t.v0 != e0 && t.v0 != e1) begin
            a = t.v2; b = t.v1;
        end else if (t.v1 != e0 && t.v1 != e1) begin
            a = t.v0; b = t.v2;
        end else if (t.v2 != e0 && t.v2 != e1) begin
            a = t.v1; b = t.v0;
        end else begin
            a = '0; b = '0;
        end
        emit(KIND_SIDE, a, b, twin_idx(a, offset_r), 0, 0, 0, 1'b0);
        emit(KIND_SIDE, b, twin_idx(b, offset_r), twin_idx(a, offset_r), 0, 0, 0, 1'b0);
    endtask

    task automatic emit_cap(int slot);
        t_tri t;
        t = tri_mem[slot];
        if (t.marked) return;
        if (t.front)
            emit(KIND_FRONT, t.v0, t.v1, t.v2, 0, 0, 0, 1'b0);
        else
            emit(KIND_BACK, twin_idx(t.v0, offset_r), twin_idx(t.v1, offset_r),
                 twin_idx(t.v2, offset_r), 0, 0, 0, 1'b0);
        tri_mem[slot].marked = 1'b1;
    endtask

    task automatic predict_item();
        int              n0 = volume_q.size();
        longint          px = i_pos_x, py = i_pos_y, pz = i_pos_z;
        longint          nx = i_nrm_x, ny = i_nrm_y, nz = i_nrm_z;
        longint          lx = lgt_x, ly = lgt_y, lz = lgt_z;
        longint          dot, dx, dy, dz, tx, ty, tz;
        longint          lim = 64'sd2147483648;
        longint unsigned len2, r2, len;
        t_tri            t0, t1;
        case (t_action'(i_action))
            ACT_LOAD: begin
                if (is_dir) dot = lx * nx + ly * ny + lz * nz;
                else        dot = (px - lx) * nx + (py - ly) * ny + (pz - lz) * nz;
                t0.v0 = i_vtx_a; t0.v1 = i_vtx_b; t0.v2 = i_vtx_c;
                t0.front  = (dot < FACE_LIMIT);
                t0.marked = 1'b0;
                tri_mem[i_slot_a] = t0;
                emit(KIND_ACK, '0, '0, '0, 0, 0, 0, t0.front);
            end
            ACT_EXTRUDE: begin
                tx = px; ty = py; tz = pz;
                if (is_dir) begin
                    tx = clamp32(px + lx); ty = clamp32(py + ly); tz = clamp32(pz + lz);
                end else begin
                    dx = px - lx; dy = py - ly; dz = pz - lz;
                    if (dx > -lim && dx < lim && dy > -lim && dy < lim &&
                        dz > -lim && dz < lim) begin
                        len2 = dx * dx + dy * dy + dz * dz;
                        r2   = longint'(range_r) * longint'(range_r);
                        if (len2 != 0 && len2 < r2) begin
                            len = root64(len2);
                            tx  = push_out(lx, dx, len);
                            ty  = push_out(ly, dy, len);
                            tz  = push_out(lz, dz, len);
                        end
                    end
                end
                emit(KIND_TWIN, '0, '0, '0, tx, ty, tz, 1'b0);
            end
            ACT_EDGE1: begin
                t0 = tri_mem[i_slot_a];
                if (t0.front) begin
                    if (!t0.marked) begin
                        emit(KIND_FRONT, t0.v0, t0.v1, t0.v2, 0, 0, 0, 1'b0);
                        emit(KIND_BACK, twin_idx(t0.v2, offset_r), twin_idx(t0.v1, offset_r),
                             twin_idx(t0.v0, offset_r), 0, 0, 0, 1'b0);
                        tri_mem[i_slot_a].marked = 1'b1;
                    end
                    emit_sides(t0, i_vtx_a, i_vtx_b);
                end
            end
            default: begin
                t0 = tri_mem[i_slot_a];
                t1 = tri_mem[i_slot_b];
                emit_cap(i_slot_a);
                emit_cap(i_slot_b);
                if (t0.front && !t1.front)      emit_sides(t0, i_vtx_a, i_vtx_b);
                else if (t1.front && !t0.front) emit_sides(t1, i_vtx_a, i_vtx_b);
            end
        endcase
        if (volume_q.size() > n0) volume_q[volume_q.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(string nm, longint unsigned expv, longint unsigned got);
        if (expv != got) begin
            $error("field %s: expected %0h, got %0h", nm, expv, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            lgt_x = '0; lgt_y = '0; lgt_z = '0;
            is_dir = 1'b0; range_r = RANGE_RESET; offset_r = '0;
            volume_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_LIGHT_X:     lgt_x    = pwdata;
                    REG_LIGHT_Y:     lgt_y    = pwdata;
                    REG_LIGHT_Z:     lgt_z    = pwdata;
                    REG_DIRECTIONAL: is_dir   = pwdata[0];
                    REG_RANGE:       range_r  = pwdata[30:0];
                    REG_TWIN_OFFSET: offset_r = pwdata[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_item();
            if (i_out_valid && i_out_ready) begin
                if (volume_q.size() == 0) begin
                    $error("result transaction with nothing expected (kind %0d)", i_kind);
                    o_fail_count++;
                end else begin
                    e = volume_q.pop_front();
                    check_field("kind", e.kind, i_kind);
                    check_field("out_a", e.a, i_out_a);
                    check_field("out_b", e.b, i_out_b);
                    check_field("out_c", e.c, i_out_c);
                    check_field("twin_x", 32'(e.tx), 32'(i_twin_x));
                    check_field("twin_y", 32'(e.ty), 32'(i_twin_y));
                    check_field("twin_z", 32'(e.tz), 32'(i_twin_z));
                    check_field("facing", e.facing, i_facing);
                    check_field("last", e.last, i_last);
                end
            end
        end
        o_pending = volume_q.size();
    end

endmodule

>>> test/shadow_volume_builder_core_tb.sv
// Testbench top for the shadow volume builder: stimulus, handshake pacing and verdict.
module shadow_volume_builder_core_tb import svb_pkg::*; ();

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 300;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    t_item                   cur = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        out_a, out_b, out_c;
    logic signed [POS_W-1:0] twin_x, twin_y, twin_z;
    logic                    facing, last;
    logic                    psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    int                      fail_count, pending;

    int                      send_idle_pct = 0;
    int                      stall_pct = 0;
    logic                    hold_req = 1'b0;
    logic                    hold_done = 1'b0;
    int                      hold_left = 0;
    int                      quiet_cycles = 0;

    // Current light settings, for aiming positions near the light.
    longint                  cur_lx, cur_ly, cur_lz, cur_range;
    logic [VTX_W-1:0]        corners [MAX_TRIANGLES][3];
    int                      loaded_slots[$];
    logic                    is_loaded [MAX_TRIANGLES];

    shadow_volume_builder_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_action(cur.action), .i_slot_a(cur.slot_a), .i_slot_b(cur.slot_b),
        .i_vtx_a(cur.vtx_a), .i_vtx_b(cur.vtx_b), .i_vtx_c(cur.vtx_c),
        .i_pos_x(cur.pos_x), .i_pos_y(cur.pos_y), .i_pos_z(cur.pos_z),
        .i_nrm_x(cur.nrm_x), .i_nrm_y(cur.nrm_y), .i_nrm_z(cur.nrm_z),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_kind(kind), .o_out_a(out_a), .o_out_b(out_b), .o_out_c(out_c),
        .o_twin_x(twin_x), .o_twin_y(twin_y), .o_twin_z(twin_z),
        .o_facing(facing), .o_last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    svb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_action(cur.action), .i_slot_a(cur.slot_a), .i_slot_b(cur.slot_b),
        .i_vtx_a(cur.vtx_a), .i_vtx_b(cur.vtx_b), .i_vtx_c(cur.vtx_c),
        .i_pos_x(cur.pos_x), .i_pos_y(cur.pos_y), .i_pos_z(cur.pos_z),
        .i_nrm_x(cur.nrm_x), .i_nrm_y(cur.nrm_y), .i_nrm_z(cur.nrm_z),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_kind(kind), .i_out_a(out_a), .i_out_b(out_b), .i_out_c(out_c),
        .i_twin_x(twin_x), .i_twin_y(twin_y), .i_twin_z(twin_z),
        .i_facing(facing), .i_last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stalls plus one long hold-off to back up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= 800;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_light(longint lx, longint ly, longint lz, logic dir,
                             longint range, int offset);
        reg_write(REG_LIGHT_X, lx[31:0]);
        reg_write(REG_LIGHT_Y, ly[31:0]);
        reg_write(REG_LIGHT_Z, lz[31:0]);
        reg_write(REG_DIRECTIONAL, {31'd0, dir});
        reg_write(REG_RANGE, range[31:0]);
        reg_write(REG_TWIN_OFFSET, offset);
        cur_lx = lx; cur_ly = ly; cur_lz = lz; cur_range = range;
    endtask

    // Drain expected results, then let a silent edge item finish.
    task automatic settle();
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send(t_item it);
        @(posedge i_clk);
        cur      <= it;
        in_valid <= 1'b1;
        if (it.action == ACT_LOAD) begin
            corners[it.slot_a] = '{it.vtx_a, it.vtx_b, it.vtx_c};
            if (!is_loaded[it.slot_a]) begin
                is_loaded[it.slot_a] = 1'b1;
                loaded_slots.push_back(it.slot_a);
            end
        end
        do @(posedge i_clk); while (!in_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end else begin
            // hold valid high; the next send call overwrites the payload
        end
    endtask

    task automatic send_op(t_action act, int sa, int sb, int va, int vb, int vc,
                           longint px, longint py, longint pz, int nx, int ny, int nz);
        t_item it;
        it.action = act; it.slot_a = sa; it.slot_b = sb;
        it.vtx_a = va; it.vtx_b = vb; it.vtx_c = vc;
        it.pos_x = px[31:0]; it.pos_y = py[31:0]; it.pos_z = pz[31:0];
        it.nrm_x = nx; it.nrm_y = ny; it.nrm_z = nz;
        send(it);
    endtask

    function automatic longint near_light(longint l);
        longint span = (cur_range > 64'd1073741824) ? 64'd1073741824 : cur_range + 1;
        return l + longint'($urandom_range(32'(2 * span))) - span;
    endfunction

    task automatic random_item();
        int     r = $urandom_range(99);
        int     sa, sb, pick;
        longint px, py, pz;
        t_item  it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
        if ($urandom_range(3) != 0) begin
            px = near_light(cur_lx); py = near_light(cur_ly); pz = near_light(cur_lz);
            it.pos_x = px[31:0]; it.pos_y = py[31:0]; it.pos_z = pz[31:0];
        end
        if (r < 30 || loaded_slots.size() == 0) begin
            it.action = ACT_LOAD;
            if ($urandom_range(3) != 0) it.slot_a = $urandom_range(15);
            if ($urandom_range(3) != 0) begin
                it.vtx_a = $urandom_range(31);
                it.vtx_b = $urandom_range(31);
                it.vtx_c = $urandom_range(31);
            end
        end else if (r < 50) begin
            it.action = ACT_EXTRUDE;
        end else begin
            it.action = (r < 75) ? ACT_EDGE1 : ACT_EDGE2;
            sa = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
            sb = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
            it.slot_a = sa;
            if (it.action == ACT_EDGE2) it.slot_b = sb;
            if ($urandom_range(4) != 0) begin
                pick     = $urandom_range(2);
                it.vtx_a = corners[sa][pick];
                it.vtx_b = corners[sa][(pick + 1 + $urandom_range(1)) % 3];
            end
        end
        send(it);
    endtask

    initial begin
        for (int s = 0; s < MAX_TRIANGLES; s++) is_loaded[s] = 1'b0;
        cur_lx = 0; cur_ly = 0; cur_lz = 0; cur_range = 65536;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings (point light at origin, unit range).
        send_op(ACT_LOAD, 0, 0, 0, 1, 2, -100, 0, 0, 16384, 0, 0);
        send_op(ACT_LOAD, 1, 0, 1, 3, 2, -10, 0, 0, 1, 0, 0);          // dot exactly at limit
        send_op(ACT_LOAD, 2, 0, 1, 2, 4, -11, 0, 0, 1, 0, 0);          // just past limit
        send_op(ACT_LOAD, 4095, 0, 65535, 65534, 65533,
                64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF, -32768, 32767, -32768);
        send_op(ACT_LOAD, 3, 0, 5, 5, 6, -200, 0, 0, 16384, 0, 0);     // degenerate corners
        send_op(ACT_EXTRUDE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);          // zero vector
        send_op(ACT_EXTRUDE, 0, 0, 0, 0, 0, 100, -300, 7, 0, 0, 0);
        send_op(ACT_EXTRUDE, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 0);      // on range
        send_op(ACT_EXTRUDE, 0, 0, 0, 0, 0, 64'sh7FFFFFFF, -64'sh80000000, 0, 0, 0, 0);
        send_op(ACT_EDGE1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);            // caps plus sides
        send_op(ACT_EDGE1, 0, 0, 1, 2, 0, 0, 0, 0, 0, 0, 0);            // sides only
        send_op(ACT_EDGE1, 1, 0, 1, 3, 0, 0, 0, 0, 0, 0, 0);            // faces away: silent
        send_op(ACT_EDGE1, 3, 0, 5, 6, 0, 0, 0, 0, 0, 0, 0);            // every corner on edge
        send_op(ACT_EDGE2, 2, 1, 1, 2, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_EDGE2, 4095, 2, 65535, 65534, 0, 0, 0, 0, 0, 0, 0);
        send_op(ACT_EDGE2, 1, 2, 2, 1, 0, 0, 0, 0, 0, 0, 0);            // both already marked
        @(posedge i_clk);
        in_valid <= 1'b0;
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_light(-3 <<< 16, 5 <<< 16, -1 <<< 16, 1'b1, 2 <<< 16, 65536);
                1: set_light(1 <<< 16, 2 <<< 16, -3 <<< 16, 1'b0, 10 <<< 16, 1000);
                2: set_light(64'sh7FFFFFFF, -64'sh80000000, 0, 1'b0, 64'h7FFFFFFF, 0);
                default: set_light(64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF, 1'b1,
                                   0, 12345);
            endcase
            send_idle_pct = (ph == 1) ? 67 : (ph == 3) ? 33 : 0;
            stall_pct     = (ph == 2) ? 67 : (ph == 3) ? 33 : 0;
            if (ph == 2) hold_req <= 1'b1;
            for (int n = 0; n < 88; n++) random_item();
            @(posedge i_clk);
            in_valid <= 1'b0;
            settle();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
